// ===== rtl/core/rnlc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rnlc_pkg;

   // Fixed field widths of the block.
   localparam int DIST_W  = 50;
   localparam int STAMP_W = 48;
   localparam int COUNT_W = 16;
   localparam int CSR_IDX_W = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_USE_HEIGHT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_SQ    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_TIME_GAP = 2'd2;

   // Values after reset.
   localparam logic [DIST_W-1:0]  RADIUS_SQ_RESET    = 50'd10000000000;
   localparam logic [STAMP_W-1:0] MIN_TIME_GAP_RESET = 48'd30000000;

   // Input word kinds.
   localparam logic KIND_QUERY    = 1'b0;
   localparam logic KIND_KEYFRAME = 1'b1;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Configuration registers as seen by the datapath.
   typedef struct packed {
      logic               use_height;
      logic [DIST_W-1:0]  radius_sq;
      logic [STAMP_W-1:0] min_time_gap;
   } cfg_type;

   // Control bits that travel with each word down the pipeline.
   typedef struct packed {
      logic valid;
      logic is_key;
      logic last;
      logic old;
   } ctl_type;

endpackage

`default_nettype wire

// ===== rtl/core/rnlc_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface rnlc_req_if #(
   parameter int INDEX_BITS = 16,
   parameter int COORD_BITS = 24
);
   import rnlc_pkg::*;

   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic signed [COORD_BITS-1:0] pos_x;
   logic signed [COORD_BITS-1:0] pos_y;
   logic signed [COORD_BITS-1:0] pos_z;
   logic [STAMP_W-1:0]           stamp;
   logic [INDEX_BITS-1:0]        node_index;
   logic                         last;

   modport source (
      output valid, kind, pos_x, pos_y, pos_z, stamp, node_index, last,
      input  ready
   );

   modport sink (
      input  valid, kind, pos_x, pos_y, pos_z, stamp, node_index, last,
      output ready
   );

endinterface

`default_nettype wire

// ===== rtl/core/rnlc_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface rnlc_rsp_if #(
   parameter int INDEX_BITS = 16
);
   import rnlc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [INDEX_BITS-1:0] query_id;
   logic [INDEX_BITS-1:0] match_id;
   logic                  found;
   logic [DIST_W-1:0]     best_dist_sq;
   logic [COUNT_W-1:0]    num_candidates;

   modport source (
      output valid, query_id, match_id, found, best_dist_sq, num_candidates,
      input  ready
   );

   modport sink (
      input  valid, query_id, match_id, found, best_dist_sq, num_candidates,
      output ready
   );

endinterface

`default_nettype wire

// ===== rtl/core/radius_nearest_loop_candidate.sv =====
`timescale 1ns / 1ps
`default_nettype none

// A result word is registered after the difference and squaring registers.
// Throughput: one word per cycle, set by the three-stage pipeline of difference, squaring
// and search update; the whole pipeline holds only while a result waits on the output.
// Reset: synchronous and active high; it clears the query, the running search, the
// pipeline valid bits and restores the configuration registers to their reset values.
module radius_nearest_loop_candidate #(
   parameter int INDEX_BITS = 16,
   parameter int COORD_BITS = 24
) (
   input  wire                                  clock,
   input  wire                                  reset,
   rnlc_req_if.sink                             req,
   rnlc_rsp_if.source                           rsp,
   input  wire                                  csr_wr_en,
   input  wire [rnlc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire [rnlc_pkg::DIST_W-1:0]           csr_wdata
);
   import rnlc_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    advance;

   ctl_type                 s1_ctl, s2_ctl;
   logic [COORD_BITS:0]     s1_dx, s1_dy, s1_dz;
   logic [INDEX_BITS-1:0]   s1_node, s2_node;
   logic [2*COORD_BITS+1:0] s2_sqx, s2_sqy, s2_sqz;

   // Configuration registers; writes to unused indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_USE_HEIGHT:   cfg_in.use_height   = csr_wdata[0];
            CSR_RADIUS_SQ:    cfg_in.radius_sq    = csr_wdata[DIST_W-1:0];
            CSR_MIN_TIME_GAP: cfg_in.min_time_gap = csr_wdata[STAMP_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.use_height   <= 1'b0;
         cfg_ff.radius_sq    <= RADIUS_SQ_RESET;
         cfg_ff.min_time_gap <= MIN_TIME_GAP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The pipeline moves whenever the result register is free or being taken.
   assign advance   = !rsp.valid || rsp.ready;
   assign req.ready = advance;

   rnlc_front #(
      .INDEX_BITS (INDEX_BITS),
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (req.valid),
      .in_kind      (req.kind),
      .in_pos_x     (req.pos_x),
      .in_pos_y     (req.pos_y),
      .in_pos_z     (req.pos_z),
      .in_stamp     (req.stamp),
      .in_node      (req.node_index),
      .in_last      (req.last),
      .min_time_gap (cfg_ff.min_time_gap),
      .s1_ctl       (s1_ctl),
      .s1_dx        (s1_dx),
      .s1_dy        (s1_dy),
      .s1_dz        (s1_dz),
      .s1_node      (s1_node)
   );

   rnlc_square #(
      .INDEX_BITS (INDEX_BITS),
      .COORD_BITS (COORD_BITS)
   ) u_square (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .s1_ctl  (s1_ctl),
      .s1_dx   (s1_dx),
      .s1_dy   (s1_dy),
      .s1_dz   (s1_dz),
      .s1_node (s1_node),
      .s2_ctl  (s2_ctl),
      .s2_sqx  (s2_sqx),
      .s2_sqy  (s2_sqy),
      .s2_sqz  (s2_sqz),
      .s2_node (s2_node)
   );

   rnlc_search #(
      .INDEX_BITS (INDEX_BITS),
      .COORD_BITS (COORD_BITS)
   ) u_search (
      .clock              (clock),
      .reset              (reset),
      .advance            (advance),
      .cfg                (cfg_ff),
      .s2_ctl             (s2_ctl),
      .s2_sqx             (s2_sqx),
      .s2_sqy             (s2_sqy),
      .s2_sqz             (s2_sqz),
      .s2_node            (s2_node),
      .out_valid          (rsp.valid),
      .out_query_id       (rsp.query_id),
      .out_match_id       (rsp.match_id),
      .out_found          (rsp.found),
      .out_best_dist_sq   (rsp.best_dist_sq),
      .out_num_candidates (rsp.num_candidates)
   );

endmodule

`default_nettype wire

// ===== rtl/core/rnlc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rnlc_front #(
   parameter int INDEX_BITS = 16,
   parameter int COORD_BITS = 24
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               advance,
   input  wire                               in_valid,
   input  wire                               in_kind,
   input  wire signed [COORD_BITS-1:0]       in_pos_x,
   input  wire signed [COORD_BITS-1:0]       in_pos_y,
   input  wire signed [COORD_BITS-1:0]       in_pos_z,
   input  wire [rnlc_pkg::STAMP_W-1:0]       in_stamp,
   input  wire [INDEX_BITS-1:0]              in_node,
   input  wire                               in_last,
   input  wire [rnlc_pkg::STAMP_W-1:0]       min_time_gap,
   output rnlc_pkg::ctl_type                 s1_ctl,
   output logic [COORD_BITS:0]               s1_dx,
   output logic [COORD_BITS:0]               s1_dy,
   output logic [COORD_BITS:0]               s1_dz,
   output logic [INDEX_BITS-1:0]             s1_node
);
   import rnlc_pkg::*;

   logic signed [COORD_BITS-1:0] qx_ff, qy_ff, qz_ff;
   logic [STAMP_W-1:0]           qstamp_ff;
   logic [INDEX_BITS-1:0]        qnode_ff;

   logic signed [COORD_BITS:0] dx_w, dy_w, dz_w;
   logic [COORD_BITS:0]        ax_w, ay_w, az_w;
   logic [STAMP_W:0]           gap_w;
   logic                       old_w;
   logic                       accept;
   logic                       load_query;

   ctl_type               ctl_ff, ctl_in;
   logic [COORD_BITS:0]   dx_ff, dy_ff, dz_ff;
   logic [INDEX_BITS-1:0] node_ff, node_in;

   assign accept     = in_valid && advance;
   assign load_query = accept && (in_kind == KIND_QUERY);

   // Coordinate differences to the loaded query, taken as magnitudes.
   assign dx_w = $signed({in_pos_x[COORD_BITS-1], in_pos_x}) - $signed({qx_ff[COORD_BITS-1], qx_ff});
   assign dy_w = $signed({in_pos_y[COORD_BITS-1], in_pos_y}) - $signed({qy_ff[COORD_BITS-1], qy_ff});
   assign dz_w = $signed({in_pos_z[COORD_BITS-1], in_pos_z}) - $signed({qz_ff[COORD_BITS-1], qz_ff});
   assign ax_w = dx_w[COORD_BITS] ? (~dx_w + 1'b1) : dx_w;
   assign ay_w = dy_w[COORD_BITS] ? (~dy_w + 1'b1) : dy_w;
   assign az_w = dz_w[COORD_BITS] ? (~dz_w + 1'b1) : dz_w;

   // The keyframe is old enough when the query is later by more than the gap.
   assign gap_w = {1'b0, qstamp_ff} - {1'b0, in_stamp};
   assign old_w = !gap_w[STAMP_W] && (gap_w[STAMP_W-1:0] > min_time_gap);

   // A closing keyframe carries the query index down the pipeline instead of its own.
   always_comb begin
      ctl_in.valid  = in_valid;
      ctl_in.is_key = (in_kind == KIND_KEYFRAME);
      ctl_in.last   = in_last;
      ctl_in.old    = old_w;
      node_in       = (in_kind == KIND_KEYFRAME && in_last) ? qnode_ff : in_node;
   end

   // Query registers load on an accepted query word.
   always_ff @(posedge clock) begin
      if (reset) begin
         qx_ff     <= '0;
         qy_ff     <= '0;
         qz_ff     <= '0;
         qstamp_ff <= '0;
         qnode_ff  <= '0;
      end else if (load_query) begin
         qx_ff     <= in_pos_x;
         qy_ff     <= in_pos_y;
         qz_ff     <= in_pos_z;
         qstamp_ff <= in_stamp;
         qnode_ff  <= in_node;
      end
   end

   // First pipeline register.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dx_ff   <= ax_w;
         dy_ff   <= ay_w;
         dz_ff   <= az_w;
         node_ff <= node_in;
      end
   end

   assign s1_ctl  = ctl_ff;
   assign s1_dx   = dx_ff;
   assign s1_dy   = dy_ff;
   assign s1_dz   = dz_ff;
   assign s1_node = node_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rnlc_square.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rnlc_square #(
   parameter int INDEX_BITS = 16,
   parameter int COORD_BITS = 24
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           advance,
   input  wire rnlc_pkg::ctl_type        s1_ctl,
   input  wire [COORD_BITS:0]            s1_dx,
   input  wire [COORD_BITS:0]            s1_dy,
   input  wire [COORD_BITS:0]            s1_dz,
   input  wire [INDEX_BITS-1:0]          s1_node,
   output rnlc_pkg::ctl_type             s2_ctl,
   output logic [2*COORD_BITS+1:0]       s2_sqx,
   output logic [2*COORD_BITS+1:0]       s2_sqy,
   output logic [2*COORD_BITS+1:0]       s2_sqz,
   output logic [INDEX_BITS-1:0]         s2_node
);
   import rnlc_pkg::*;

   localparam int SQ_W = 2 * COORD_BITS + 2;

   logic [SQ_W-1:0] sqx_in, sqy_in, sqz_in;
   logic [SQ_W-1:0] sqx_ff, sqy_ff, sqz_ff;
   logic [INDEX_BITS-1:0] node_ff;
   ctl_type ctl_ff;

   // Three squarers, one per axis.
   assign sqx_in = s1_dx * s1_dx;
   assign sqy_in = s1_dy * s1_dy;
   assign sqz_in = s1_dz * s1_dz;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= s1_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sqx_ff  <= sqx_in;
         sqy_ff  <= sqy_in;
         sqz_ff  <= sqz_in;
         node_ff <= s1_node;
      end
   end

   assign s2_ctl  = ctl_ff;
   assign s2_sqx  = sqx_ff;
   assign s2_sqy  = sqy_ff;
   assign s2_sqz  = sqz_ff;
   assign s2_node = node_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rnlc_search.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rnlc_search #(
   parameter int INDEX_BITS = 16,
   parameter int COORD_BITS = 24
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              advance,
   input  wire rnlc_pkg::cfg_type           cfg,
   input  wire rnlc_pkg::ctl_type           s2_ctl,
   input  wire [2*COORD_BITS+1:0]           s2_sqx,
   input  wire [2*COORD_BITS+1:0]           s2_sqy,
   input  wire [2*COORD_BITS+1:0]           s2_sqz,
   input  wire [INDEX_BITS-1:0]             s2_node,
   output logic                             out_valid,
   output logic [INDEX_BITS-1:0]            out_query_id,
   output logic [INDEX_BITS-1:0]            out_match_id,
   output logic                             out_found,
   output logic [rnlc_pkg::DIST_W-1:0]      out_best_dist_sq,
   output logic [rnlc_pkg::COUNT_W-1:0]     out_num_candidates
);
   import rnlc_pkg::*;

   localparam int SQ_W  = 2 * COORD_BITS + 2;
   localparam int SUM_RAW_W = SQ_W + 2;
   localparam int SUM_W = (SUM_RAW_W > DIST_W) ? SUM_RAW_W : DIST_W + 1;

   logic [SUM_W-1:0]  sum_w;
   logic [DIST_W-1:0] dist_w;
   logic              hit_w;
   logic              take_w;
   logic              step_w;
   logic              close_w;

   logic [DIST_W-1:0]     best_dist_ff, best_dist_in;
   logic [INDEX_BITS-1:0] best_node_ff, best_node_in;
   logic                  any_found_ff, any_found_in;
   logic [COUNT_W-1:0]    hit_count_ff, hit_count_in;

   logic                  rsp_valid_ff;
   logic [INDEX_BITS-1:0] rsp_query_ff, rsp_match_ff;
   logic                  rsp_found_ff;
   logic [DIST_W-1:0]     rsp_dist_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;

   // Squared distance, saturated to the result width.
   assign sum_w  = SUM_W'(s2_sqx) + SUM_W'(s2_sqy)
                 + (cfg.use_height ? SUM_W'(s2_sqz) : SUM_W'(0));
   assign dist_w = (|sum_w[SUM_W-1:DIST_W]) ? {DIST_W{1'b1}} : sum_w[DIST_W-1:0];

   assign step_w  = advance && s2_ctl.valid;
   assign close_w = step_w && s2_ctl.is_key && s2_ctl.last;
   assign hit_w   = s2_ctl.is_key && !s2_ctl.last && s2_ctl.old && (dist_w < cfg.radius_sq);
   assign take_w  = hit_w && (!any_found_ff || (dist_w < best_dist_ff));

   // Running search: cleared by a query word or a closing keyframe.
   always_comb begin
      best_dist_in = best_dist_ff;
      best_node_in = best_node_ff;
      any_found_in = any_found_ff;
      hit_count_in = hit_count_ff;
      if (step_w) begin
         if (!s2_ctl.is_key || s2_ctl.last) begin
            best_dist_in = '0;
            best_node_in = '0;
            any_found_in = 1'b0;
            hit_count_in = '0;
         end else if (hit_w) begin
            if (hit_count_ff != COUNT_MAX) begin
               hit_count_in = hit_count_ff + 1'b1;
            end
            if (take_w) begin
               best_dist_in = dist_w;
               best_node_in = s2_node;
               any_found_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_dist_ff <= '0;
         best_node_ff <= '0;
         any_found_ff <= 1'b0;
         hit_count_ff <= '0;
      end else begin
         best_dist_ff <= best_dist_in;
         best_node_ff <= best_node_in;
         any_found_ff <= any_found_in;
         hit_count_ff <= hit_count_in;
      end
   end

   // Result register; the node field of a closing keyframe holds the query index.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s2_ctl.valid && s2_ctl.is_key && s2_ctl.last;
      end
   end

   always_ff @(posedge clock) begin
      if (close_w) begin
         rsp_query_ff <= s2_node;
         rsp_match_ff <= best_node_ff;
         rsp_found_ff <= any_found_ff;
         rsp_dist_ff  <= best_dist_ff;
         rsp_count_ff <= hit_count_ff;
      end
   end

   assign out_valid          = rsp_valid_ff;
   assign out_query_id       = rsp_query_ff;
   assign out_match_id       = rsp_match_ff;
   assign out_found          = rsp_found_ff;
   assign out_best_dist_sq   = rsp_dist_ff;
   assign out_num_candidates = rsp_count_ff;

`ifndef NO_ASSERTIONS
   // Found flag and candidate count agree.
   a_count_without_match: assert property (@(posedge clock) disable iff (reset)
      !any_found_ff |-> (hit_count_ff == '0))
      else $error("candidates counted with no match held");

   a_match_without_count: assert property (@(posedge clock) disable iff (reset)
      any_found_ff |-> (hit_count_ff != '0))
      else $error("match held with zero candidate count");

   // An empty search reports zero match index and distance.
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_match_ff == '0 && rsp_dist_ff == '0))
      else $error("empty result carries match data");

   // A query word or closing keyframe leaves the search cleared.
   a_cleared: assert property (@(posedge clock) disable iff (reset)
      (step_w && (!s2_ctl.is_key || s2_ctl.last)) |=> (!any_found_ff && hit_count_ff == '0))
      else $error("search not cleared");
`endif

endmodule

`default_nettype wire
